// ----- hdl/moving_average_filter_macros.svh -----
// Assertion helpers shared by the filter modules.
// Both need a signal named clock in the using module; MAF_ASSERT also needs reset.
`ifndef MOVING_AVERAGE_FILTER_MACROS_SVH
`define MOVING_AVERAGE_FILTER_MACROS_SVH

// Checked on every edge outside of reset.
`define MAF_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every edge, reset included.
`define MAF_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ----- hdl/maf_pkg.sv -----
package maf_pkg;

   // Defaults for the top level parameters
   localparam int MAX_TAPS_DEF    = 64;
   localparam int SAMPLE_BITS_DEF = 16;

   // Window length register
   localparam int CSR_BITS     = 7;
   localparam int WINDOW_RESET = 16;

   // Entries between front and back
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic {
      OP_ADD   = 1'b0,
      OP_CLEAR = 1'b1
   } op_type;

   typedef enum logic {
      FR_IDLE,
      FR_UPDATE
   } front_state_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_DIV,
      BK_OUT
   } back_state_type;

   // Queue status seen by the producer and the consumer
   typedef struct packed {
      logic has_space;
      logic not_empty;
   } qstat_type;

endpackage

// ----- hdl/maf_if.sv -----
// Request channel: one beat per sample or clear.
interface maf_req_if #(
   parameter int SAMPLE_BITS = maf_pkg::SAMPLE_BITS_DEF
);
   logic                          valid;
   logic                          ready;
   logic                          operation;
   logic signed [SAMPLE_BITS-1:0] sample;

   modport source (output valid, output operation, output sample, input ready);
   modport sink   (input valid, input operation, input sample, output ready);
endinterface

// Response channel: one beat per request.
interface maf_rsp_if #(
   parameter int SAMPLE_BITS = maf_pkg::SAMPLE_BITS_DEF
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] average;

   modport source (output valid, output average, input ready);
   modport sink   (input valid, input average, output ready);
endinterface

// ----- hdl/maf_ram.sv -----
module maf_ram #(
   parameter int WIDTH     = 16,
   parameter int DEPTH     = 64,
   parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/maf_queue.sv -----
module maf_queue #(
   parameter int WIDTH = 23,
   parameter int DEPTH = maf_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  logic [WIDTH-1:0]   push_data,
   input  logic               pop,
   output logic [WIDTH-1:0]   pop_data,
   output maf_pkg::qstat_type qstat
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]    entry_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;

   // Advance pointers and track occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed entry
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data        = entry_ff[rd_ptr_ff];
   assign qstat.has_space = (count_ff != CNT_BITS'(DEPTH));
   assign qstat.not_empty = (count_ff != '0);

endmodule

// ----- hdl/maf_front.sv -----
`include "moving_average_filter_macros.svh"

module maf_front #(
   parameter int MAX_TAPS    = maf_pkg::MAX_TAPS_DEF,
   parameter int SAMPLE_BITS = maf_pkg::SAMPLE_BITS_DEF,
   parameter int SUM_BITS    = SAMPLE_BITS + $clog2(MAX_TAPS),
   parameter int WIN_BITS    = $clog2(MAX_TAPS + 1),
   parameter int PTR_BITS    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [WIN_BITS-1:0]   win,
   input  logic                  cfg_clear,
   maf_req_if.sink               req,
   output logic                  ram_rd_en,
   output logic [PTR_BITS-1:0]   ram_rd_addr,
   input  logic [SAMPLE_BITS-1:0] ram_rd_data,
   output logic                  ram_wr_en,
   output logic [PTR_BITS-1:0]   ram_wr_addr,
   output logic [SAMPLE_BITS-1:0] ram_wr_data,
   output logic                  push,
   output logic [SUM_BITS:0]     push_data,
   input  maf_pkg::qstat_type    qstat
);

   localparam int ADR_BITS = WIN_BITS + 1;

   maf_pkg::front_state_type      state_ff, state_in;
   maf_pkg::op_type               op_ff;
   logic signed [SAMPLE_BITS-1:0] sample_ff;
   logic [PTR_BITS-1:0]           wp_ff, wp_in;
   logic [WIN_BITS-1:0]           fill_ff, fill_in;
   logic signed [SUM_BITS-1:0]    sum_ff, sum_in;

   logic                          accept;
   logic                          is_add;
   logic [ADR_BITS-1:0]           wp_ext;
   logic [ADR_BITS-1:0]           win_ext;
   logic [ADR_BITS-1:0]           back_addr;
   logic signed [SAMPLE_BITS-1:0] leaving;
   logic signed [SUM_BITS-1:0]    sum_upd;

   assign accept = req.valid && req.ready;
   assign is_add = (op_ff == maf_pkg::OP_ADD);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         maf_pkg::FR_IDLE: begin
            if (accept) begin
               state_in = maf_pkg::FR_UPDATE;
            end
         end
         maf_pkg::FR_UPDATE: begin
            state_in = maf_pkg::FR_IDLE;
         end
         default: begin
            state_in = maf_pkg::FR_IDLE;
         end
      endcase
   end

   // Outputs of the state machine
   always_comb begin
      req.ready = 1'b0;
      push      = 1'b0;
      ram_rd_en = 1'b0;
      ram_wr_en = 1'b0;
      case (state_ff)
         maf_pkg::FR_IDLE: begin
            req.ready = qstat.has_space;
            ram_rd_en = accept;
         end
         maf_pkg::FR_UPDATE: begin
            push      = 1'b1;
            ram_wr_en = is_add;
         end
         default: begin
            req.ready = 1'b0;
         end
      endcase
   end

   // Address of the sample that drops out of the window
   always_comb begin
      wp_ext  = ADR_BITS'(wp_ff);
      win_ext = ADR_BITS'(win);
      if (wp_ext >= win_ext) begin
         back_addr = wp_ext - win_ext;
      end else begin
         back_addr = wp_ext + ADR_BITS'(MAX_TAPS) - win_ext;
      end
   end

   assign ram_rd_addr = back_addr[PTR_BITS-1:0];
   assign ram_wr_addr = wp_ff;
   assign ram_wr_data = sample_ff;

   // Running sum: add the new sample, drop the leaving one once the window is full
   assign leaving   = (fill_ff == win) ? signed'(ram_rd_data) : '0;
   assign sum_upd   = sum_ff + SUM_BITS'(sample_ff) - SUM_BITS'(leaving);
   assign push_data = {!is_add, (is_add ? sum_upd : '0)};

   // Update history pointers and sum
   always_comb begin
      wp_in   = wp_ff;
      fill_in = fill_ff;
      sum_in  = sum_ff;
      if (cfg_clear) begin
         fill_in = '0;
         sum_in  = '0;
      end else if (state_ff == maf_pkg::FR_UPDATE) begin
         if (is_add) begin
            sum_in  = sum_upd;
            fill_in = (fill_ff == win) ? fill_ff : fill_ff + 1'b1;
            wp_in   = (wp_ff == PTR_BITS'(MAX_TAPS - 1)) ? '0 : wp_ff + 1'b1;
         end else begin
            fill_in = '0;
            sum_in  = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= maf_pkg::FR_IDLE;
         wp_ff    <= '0;
         fill_ff  <= '0;
         sum_ff   <= '0;
      end else begin
         state_ff <= state_in;
         wp_ff    <= wp_in;
         fill_ff  <= fill_in;
         sum_ff   <= sum_in;
      end
   end

   // Hold the accepted beat for the update cycle
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff     <= maf_pkg::op_type'(req.operation);
         sample_ff <= req.sample;
      end
   end

   `MAF_ASSERT(a_fill_within_window, fill_ff <= win, "fill count beyond window length")
   `MAF_ASSERT(a_push_has_space, push |-> qstat.has_space, "push into a full queue")

endmodule

// ----- hdl/maf_back.sv -----
`include "moving_average_filter_macros.svh"

module maf_back #(
   parameter int SAMPLE_BITS = maf_pkg::SAMPLE_BITS_DEF,
   parameter int SUM_BITS    = SAMPLE_BITS + 6,
   parameter int WIN_BITS    = 7
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [WIN_BITS-1:0] win,
   output logic               pop,
   input  logic [SUM_BITS:0]  pop_data,
   input  maf_pkg::qstat_type qstat,
   maf_rsp_if.source          rsp
);

   localparam int CNT_BITS = $clog2(SUM_BITS);
   localparam logic [SUM_BITS-1:0] POS_MAX =
      SUM_BITS'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);

   maf_pkg::back_state_type state_ff, state_in;
   logic [SUM_BITS-1:0]     dvd_ff, dvd_in;
   logic [WIN_BITS-1:0]     rem_ff, rem_in;
   logic [CNT_BITS-1:0]     cnt_ff, cnt_in;
   logic                    neg_ff, neg_in;
   logic [SAMPLE_BITS-1:0]  avg_ff, avg_in;

   logic                    entry_clear;
   logic [SUM_BITS-1:0]     entry_sum;
   logic                    last_step;
   logic [WIN_BITS:0]       trial;
   logic                    q_bit;
   logic [WIN_BITS-1:0]     rem_step;
   logic [SUM_BITS-1:0]     dvd_step;
   logic [SUM_BITS-1:0]     quot_signed;

   assign entry_clear = pop_data[SUM_BITS];
   assign entry_sum   = pop_data[SUM_BITS-1:0];
   assign last_step   = (cnt_ff == CNT_BITS'(SUM_BITS - 1));

   // One restoring divide step: shift in a dividend bit, subtract if it fits
   always_comb begin
      trial = {rem_ff, dvd_ff[SUM_BITS-1]};
      q_bit = (trial >= {1'b0, win});
      if (q_bit) begin
         rem_step = WIN_BITS'(trial - {1'b0, win});
      end else begin
         rem_step = trial[WIN_BITS-1:0];
      end
      dvd_step    = {dvd_ff[SUM_BITS-2:0], q_bit};
      quot_signed = neg_ff ? (~dvd_step + 1'b1) : dvd_step;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         maf_pkg::BK_IDLE: begin
            if (qstat.not_empty) begin
               state_in = entry_clear ? maf_pkg::BK_OUT : maf_pkg::BK_DIV;
            end
         end
         maf_pkg::BK_DIV: begin
            if (last_step) begin
               state_in = maf_pkg::BK_OUT;
            end
         end
         maf_pkg::BK_OUT: begin
            if (rsp.ready) begin
               state_in = maf_pkg::BK_IDLE;
            end
         end
         default: begin
            state_in = maf_pkg::BK_IDLE;
         end
      endcase
   end

   // Outputs of the state machine
   always_comb begin
      pop       = 1'b0;
      rsp.valid = 1'b0;
      case (state_ff)
         maf_pkg::BK_IDLE: begin
            pop = qstat.not_empty;
         end
         maf_pkg::BK_DIV: begin
            pop = 1'b0;
         end
         maf_pkg::BK_OUT: begin
            rsp.valid = 1'b1;
         end
         default: begin
            pop = 1'b0;
         end
      endcase
   end

   assign rsp.average = avg_ff;

   // Datapath: load magnitude, iterate, then sign the quotient
   always_comb begin
      dvd_in = dvd_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      neg_in = neg_ff;
      avg_in = avg_ff;
      case (state_ff)
         maf_pkg::BK_IDLE: begin
            neg_in = entry_sum[SUM_BITS-1];
            dvd_in = entry_sum[SUM_BITS-1] ? (~entry_sum + 1'b1) : entry_sum;
            rem_in = '0;
            cnt_in = '0;
            avg_in = '0;
         end
         maf_pkg::BK_DIV: begin
            dvd_in = dvd_step;
            rem_in = rem_step;
            cnt_in = cnt_ff + 1'b1;
            if (last_step) begin
               avg_in = quot_signed[SAMPLE_BITS-1:0];
            end
         end
         maf_pkg::BK_OUT: begin
            avg_in = avg_ff;
         end
         default: begin
            avg_in = avg_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= maf_pkg::BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
      avg_ff <= avg_in;
   end

   `MAF_ASSERT(a_rem_below_win, (state_ff == maf_pkg::BK_DIV) |-> (rem_ff < win), "partial remainder not below window length")
   `MAF_ASSERT(a_clear_gives_zero, (pop && entry_clear) |=> ((state_ff == maf_pkg::BK_OUT) && (avg_ff == '0)), "clear beat did not give a zero average")
   `MAF_ASSERT(a_quot_in_range, ((state_ff == maf_pkg::BK_OUT) && ($past(state_ff) == maf_pkg::BK_DIV) && !neg_ff) |-> (dvd_ff <= POS_MAX), "positive average out of sample range")

endmodule

// ----- hdl/moving_average_filter.sv -----
// Channel  Dir  Payload                         Beat
// req_bus  in   operation (add/clear), sample   one per sample or clear
// rsp_bus  out  average                         one per req beat
// csr_*    in   csr_wr_data = window length     write on csr_wr_en
//
// The front accepts a req beat only in idle with queue space, then updates the
// sum (history read, then sum update) and pushes it into a 2-entry queue; the
// back divides each sum bit-serially, one quotient bit per cycle, and takes no
// new entry until its response is taken. A clear beat skips the divide.
// Reset is synchronous; history and sum read as zero after reset, clear or a
// csr write. A stalled rsp holds the back while the front fills the queue.
module moving_average_filter #(
   parameter int MAX_TAPS    = maf_pkg::MAX_TAPS_DEF,
   parameter int SAMPLE_BITS = maf_pkg::SAMPLE_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   maf_req_if.sink                      req_bus,
   maf_rsp_if.source                    rsp_bus,
   input  logic                         csr_wr_en,
   input  logic [maf_pkg::CSR_BITS-1:0] csr_wr_data
);

   localparam int WIN_BITS = $clog2(MAX_TAPS + 1);
   localparam int PTR_BITS = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
   localparam int SUM_BITS = SAMPLE_BITS + $clog2(MAX_TAPS);
   localparam int CMP_BITS = (WIN_BITS > maf_pkg::CSR_BITS) ? WIN_BITS : maf_pkg::CSR_BITS;
   localparam int WIN_RST  = (maf_pkg::WINDOW_RESET > MAX_TAPS) ? MAX_TAPS
                                                                : maf_pkg::WINDOW_RESET;

   logic [WIN_BITS-1:0]    win_ff, win_in;
   logic [CMP_BITS-1:0]    csr_ext;

   logic                   ram_rd_en;
   logic [PTR_BITS-1:0]    ram_rd_addr;
   logic [SAMPLE_BITS-1:0] ram_rd_data;
   logic                   ram_wr_en;
   logic [PTR_BITS-1:0]    ram_wr_addr;
   logic [SAMPLE_BITS-1:0] ram_wr_data;

   logic                   push;
   logic [SUM_BITS:0]      push_data;
   logic                   pop;
   logic [SUM_BITS:0]      pop_data;
   maf_pkg::qstat_type     qstat;

   // Saturate the written window length to 1..MAX_TAPS
   always_comb begin
      csr_ext = CMP_BITS'(csr_wr_data);
      win_in  = win_ff;
      if (csr_wr_en) begin
         if (csr_ext == '0) begin
            win_in = WIN_BITS'(1);
         end else if (csr_ext > CMP_BITS'(MAX_TAPS)) begin
            win_in = WIN_BITS'(MAX_TAPS);
         end else begin
            win_in = csr_ext[WIN_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= WIN_BITS'(WIN_RST);
      end else begin
         win_ff <= win_in;
      end
   end

   maf_ram #(
      .WIDTH     (SAMPLE_BITS),
      .DEPTH     (MAX_TAPS),
      .ADDR_BITS (PTR_BITS)
   ) u_history (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   maf_front #(
      .MAX_TAPS    (MAX_TAPS),
      .SAMPLE_BITS (SAMPLE_BITS),
      .SUM_BITS    (SUM_BITS),
      .WIN_BITS    (WIN_BITS),
      .PTR_BITS    (PTR_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .win         (win_ff),
      .cfg_clear   (csr_wr_en),
      .req         (req_bus),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .push        (push),
      .push_data   (push_data),
      .qstat       (qstat)
   );

   maf_queue #(
      .WIDTH (SUM_BITS + 1),
      .DEPTH (maf_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .qstat     (qstat)
   );

   maf_back #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .SUM_BITS    (SUM_BITS),
      .WIN_BITS    (WIN_BITS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .win      (win_ff),
      .pop      (pop),
      .pop_data (pop_data),
      .qstat    (qstat),
      .rsp      (rsp_bus)
   );

endmodule
